// ===== rtl/crpm_pkg.sv =====
// crpm_pkg: shared constants for the crank period speed meter.
// Register indexes, reset values and field widths. No dependencies.
`default_nettype none

package crpm_pkg;

  localparam int TIME_WIDTH_DEF = 64;

  localparam int SPEED_W = 17;
  localparam int REVS_W  = 32;
  localparam int NOISE_W = 16;
  localparam int TMO_W   = 32;
  localparam int LIMIT_W = 16;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 8;

  // Dividend for the speed: two revolutions' worth of microseconds per minute
  localparam int QUOT_W = 27;
  localparam logic [QUOT_W-1:0] TICKS_X2 = 27'd120000000;

  localparam logic [SPEED_W-1:0] NOISE_CODE = '1;

  localparam logic [IDX_W-1:0] REG_NOISE_GAP   = 8'd0;
  localparam logic [IDX_W-1:0] REG_RUN_TIMEOUT = 8'd1;
  localparam logic [IDX_W-1:0] REG_RPM_LIMIT   = 8'd2;

  localparam logic [NOISE_W-1:0] NOISE_GAP_RST   = 16'd40;
  localparam logic [TMO_W-1:0]   RUN_TIMEOUT_RST = 32'd1000000;
  localparam logic [LIMIT_W-1:0] RPM_LIMIT_RST   = 16'd30000;

  // Stream payload widths; the data widths are padded to whole bytes
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

endpackage

`default_nettype wire

// ===== rtl/crank_period_rpm_meter.sv =====
// crank_period_rpm_meter: period-measuring tachometer on timestamped trigger transactions.
// Each transaction runs through the gap, evaluate and finish states; a sync that divides
// also runs the divide and limit states. One transaction in flight; finish holds until
// the output register is free. Radix-2 restoring divider, one quotient bit a cycle over 27 bits.
// A finished result waits in the output register while the next transaction is taken.
// Reset (synchronous, rst_n low) clears speed, revolutions and sync history and
// returns the registers to their defaults.
`default_nettype none

module crank_period_rpm_meter #(
  parameter int TIME_WIDTH = crpm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [crpm_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [crpm_pkg::CFG_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [crpm_pkg::IN_DATA_W-1:0]  in_tdata,   // [63:0] time_us
  input  wire logic                            in_tuser,   // [0] is_sync
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [crpm_pkg::OUT_DATA_W-1:0]      out_tdata,  // [16:0] speed_rpm, [48:17] revolution_count
  output logic [crpm_pkg::OUT_USER_W-1:0]      out_tuser   // [0] running, [1] noisy
);

  import crpm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GAP  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_LIM  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic [2:0]            state_r, state_nxt;

  logic [NOISE_W-1:0]    noise_gap_r;
  logic [TMO_W-1:0]      run_timeout_r;
  logic [LIMIT_W-1:0]    rpm_limit_r;

  logic [TIME_WIDTH-1:0] now_r;
  logic                  sync_r;
  logic [TIME_WIDTH-1:0] gap_r;
  logic                  in_window_r;

  logic [TIME_WIDTH-1:0] last_sync_r;
  logic                  have_sync_r;
  logic [SPEED_W-1:0]    speed_r, speed_nxt;
  logic [REVS_W-1:0]     revs_r;

  // divider
  logic [TMO_W-1:0]      rem_r, rem_nxt;
  logic [QUOT_W-1:0]     dvd_r, dvd_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TMO_W:0]        rem_shift;
  logic [TMO_W:0]        rem_diff;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  gap_lt_tmo;
  logic                  run_fin;
  logic [SPEED_W-1:0]    speed_out;
  logic [REVS_W-1:0]     revs_fin;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign gap_lt_tmo = gap_r < TIME_WIDTH'(run_timeout_r);

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, dvd_r[QUOT_W-1]};
  assign rem_diff  = rem_shift - {1'b0, gap_r[TMO_W-1:0]};

  // After a sync the gap is zero, so running only needs a non-zero timeout
  assign run_fin   = sync_r ? (run_timeout_r != '0) : (have_sync_r && in_window_r);
  assign speed_out = run_fin ? speed_r : '0;
  assign revs_fin  = sync_r ? revs_r + 1'b1 : revs_r;

  always_comb begin
    state_nxt = state_r;
    speed_nxt = speed_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_FIN;
        if (sync_r && have_sync_r && gap_lt_tmo) begin
          if (gap_r < TIME_WIDTH'(noise_gap_r) || gap_r == '0) begin
            speed_nxt = NOISE_CODE;
          end else begin
            rem_nxt   = '0;
            dvd_nxt   = TICKS_X2;
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        dvd_nxt = {dvd_r[QUOT_W-2:0], 1'b0};
        if (!rem_diff[TMO_W]) begin
          rem_nxt = rem_diff[TMO_W-1:0];
          quo_nxt = {quo_r[QUOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[TMO_W-1:0];
          quo_nxt = {quo_r[QUOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        if (quo_r > QUOT_W'(rpm_limit_r)) begin
          speed_nxt = NOISE_CODE;
        end else begin
          speed_nxt = SPEED_W'(quo_r);
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      noise_gap_r   <= NOISE_GAP_RST;
      run_timeout_r <= RUN_TIMEOUT_RST;
      rpm_limit_r   <= RPM_LIMIT_RST;
      last_sync_r   <= '0;
      have_sync_r   <= 1'b0;
      speed_r       <= '0;
      revs_r        <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NOISE_GAP:   noise_gap_r   <= cfg_wdata[NOISE_W-1:0];
          REG_RUN_TIMEOUT: run_timeout_r <= cfg_wdata[TMO_W-1:0];
          REG_RPM_LIMIT:   rpm_limit_r   <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
        revs_r       <= revs_fin;
        if (sync_r) begin
          last_sync_r <= now_r;
          have_sync_r <= 1'b1;
        end
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (in_acc) begin
      now_r  <= in_tdata[TIME_WIDTH-1:0];
      sync_r <= in_tuser;
    end
    if (state_r == ST_GAP) begin
      gap_r <= now_r - last_sync_r;
    end
    if (state_r == ST_EVAL) begin
      in_window_r <= gap_lt_tmo;
    end
    if (state_r == ST_FIN && out_free) begin
      out_tdata_r <= {{(OUT_DATA_W - SPEED_W - REVS_W){1'b0}}, revs_fin, speed_out};
      out_tuser_r <= {(speed_r == NOISE_CODE), run_fin};
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_crank_period_rpm_meter.sv =====
`timescale 1ns / 1ps
// tb_crank_period_rpm_meter: self-checking regression for the crank period speed meter.
// Streams timestamped trigger transactions and checks each result against a local
// prediction of the meter state. Depends on crpm_pkg and crank_period_rpm_meter.

module tb_crank_period_rpm_meter;
  import crpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam logic [63:0] US_PER_MIN_X2 = 64'd120_000_000;
  // indexes past the register file, must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE = 8'd3;
  localparam logic [IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               running;
    logic               noisy;
    logic [REVS_W-1:0]  revs;
  } reading_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [63:0] time_us
  logic                  in_tuser   = 1'b0;  // [0] is_sync
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [16:0] speed_rpm, [48:17] revolution_count
  logic [OUT_USER_W-1:0] out_tuser;  // [0] running, [1] noisy

  // predicted meter state and register copies, reset values
  logic [63:0]        exp_last_sync = '0;
  logic               exp_have_sync = 1'b0;
  logic [SPEED_W-1:0] exp_speed     = '0;
  logic [REVS_W-1:0]  exp_revs      = '0;
  logic [NOISE_W-1:0] cur_noise_gap = 16'd40;
  logic [TMO_W-1:0]   cur_timeout   = 32'd1_000_000;
  logic [LIMIT_W-1:0] cur_limit     = 16'd30000;

  reading_t    pending_readings[$];
  int unsigned err_count   = 0;
  int unsigned result_idx  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  bit          hold_req    = 1'b0;

  crank_period_rpm_meter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("crank_period_rpm_meter regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic in_run_window(input logic [63:0] now);
    logic [63:0] since;
    since = now - exp_last_sync;
    return exp_have_sync && (since < {32'd0, cur_timeout});
  endfunction

  function automatic reading_t advance_meter(input logic [63:0] now, input logic sync);
    logic [63:0] since;
    logic [63:0] quot;
    reading_t    r;
    if (sync) begin
      exp_revs = exp_revs + 1'b1;
      if (in_run_window(now)) begin
        since = now - exp_last_sync;
        // zero gap never divides, even with a zero threshold
        if (since < {48'd0, cur_noise_gap} || since == 64'd0) begin
          exp_speed = NOISE_CODE;
        end else begin
          quot = US_PER_MIN_X2 / since;
          exp_speed = (quot > {48'd0, cur_limit}) ? NOISE_CODE : quot[SPEED_W-1:0];
        end
      end
      exp_last_sync = now;
      exp_have_sync = 1'b1;
    end
    r.running = in_run_window(now);
    r.speed   = r.running ? exp_speed : '0;
    r.noisy   = (exp_speed == NOISE_CODE);
    r.revs    = exp_revs;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_REPORTS) begin
      $display("ERROR result %0d: %s is 0x%0h, predicted 0x%0h", result_idx, what, got, want);
    end
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_tdata), '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[SPEED_W-1:0] !== want.speed)
          report_mismatch("speed_rpm", 64'(out_tdata[SPEED_W-1:0]), 64'(want.speed));
        if (out_tdata[SPEED_W +: REVS_W] !== want.revs)
          report_mismatch("revolution_count", 64'(out_tdata[SPEED_W +: REVS_W]),
                          64'(want.revs));
        if (out_tuser[0] !== want.running)
          report_mismatch("running", 64'(out_tuser[0]), 64'(want.running));
        if (out_tuser[1] !== want.noisy)
          report_mismatch("noisy", 64'(out_tuser[1]), 64'(want.noisy));
      end
      result_idx++;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid === 1'b1 && out_tready)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_event(input logic [63:0] t, input logic sync);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    in_tuser  <= sync;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(advance_meter(t, sync));
  endtask

  task automatic sync_after(input logic [63:0] gap);
    send_event(exp_last_sync + gap, 1'b1);
  endtask

  // every transaction yields a result, so an empty queue means the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_NOISE_GAP:   cur_noise_gap = val[NOISE_W-1:0];
      REG_RUN_TIMEOUT: cur_timeout   = val[TMO_W-1:0];
      REG_RPM_LIMIT:   cur_limit     = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_meter(input logic [NOISE_W-1:0] noise, input logic [TMO_W-1:0] tmo,
                           input logic [LIMIT_W-1:0] lim);
    drain();
    write_reg(REG_NOISE_GAP, CFG_W'(noise));
    write_reg(REG_RUN_TIMEOUT, tmo);
    write_reg(REG_RPM_LIMIT, CFG_W'(lim));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_power_on();
    send_event(64'd0, 1'b0);
    send_event('1, 1'b0);
    send_event(64'd1000, 1'b1);      // first sync: counted, speed untouched
    sync_after(64'd4000);            // lands exactly on the default limit
    sync_after(64'd3999);            // one step above the limit
    sync_after(64'd39);              // under the noise gap
    sync_after(64'd20000);
    sync_after(64'd999_999);         // last gap inside the timeout
    sync_after(64'd1_000_000);       // equal to timeout: speed kept, time moves
    send_event(64'hFFFF_FFFF_FFFF_F000, 1'b1);
    sync_after(64'h2000);            // wraps through zero
    send_event(exp_last_sync - 64'd1, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_meter(16'd0, 32'd1_000_000, 16'd30000);
    send_event(64'd100, 1'b1);
    sync_after(64'd0);               // zero gap with zero threshold
    set_meter(16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    sync_after(64'd1831);
    sync_after(64'd1832);
    sync_after(64'd200_000_000);     // quotient rounds to zero
    set_meter(16'hFFFF, 32'd0, 16'd1);
    sync_after(64'd5);               // zero timeout never runs
    set_meter(16'hFFFF, 32'hFFFF_FFFF, 16'd1);
    sync_after(64'd65534);
    sync_after(64'd120_000_000);
    // spare indexes and upper data bits are dropped
    drain();
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, '1);
    write_reg(REG_NOISE_GAP, 32'hFFFF_0028);
    write_reg(REG_RUN_TIMEOUT, 32'd1_000_000);
    write_reg(REG_RPM_LIMIT, 32'hFFFF_7530);
    cfg_we <= 1'b0;
    sync_after(64'd39);
    sync_after(64'd4000);
  endtask

  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (24) sync_after(64'($urandom_range(2000, 60000)));
    drain();
    no_idle = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [NOISE_W-1:0] noise;
    logic [TMO_W-1:0]   tmo;
    logic [LIMIT_W-1:0] lim;
    logic [63:0]        span;
    int unsigned        sent;
    int unsigned        k;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          noise = 16'd40; tmo = 32'd1_000_000; lim = 16'd30000;
        end
        1: begin
          noise = 16'd0; tmo = 32'hFFFF_FFFF; lim = 16'hFFFF;
        end
        2: begin
          noise = 16'hFFFF; tmo = 32'd200_000; lim = 16'd1;
        end
        3: begin
          noise = NOISE_W'($urandom_range(0, 200)); tmo = 32'd1;
          lim   = LIMIT_W'($urandom_range(1, 65535));
        end
        default: begin
          noise = NOISE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 200));
          tmo   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(5000, 4_000_000);
          lim   = LIMIT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                        : $urandom_range(500, 12000));
        end
      endcase
      set_meter(noise, tmo, lim);
      no_idle = (p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray transaction anywhere on the time line
          send_event({$urandom, $urandom}, $urandom_range(0, 3) == 0);
          sent++;
        end else begin
          // one revolution: up to three plain teeth, then the sync tooth
          case ($urandom_range(0, 9))
            0: span = 64'($urandom_range(0, cur_noise_gap + 2));
            1: span = US_PER_MIN_X2 / cur_limit - 64'd1 + 64'($urandom_range(0, 2));
            2: span = {32'd0, cur_timeout} - 64'd1 + 64'($urandom_range(0, 2));
            3: span = {$urandom, $urandom};
            default: span = 64'($urandom_range(2000, 400_000));
          endcase
          k = $urandom_range(0, 3);
          repeat (k) send_event(exp_last_sync + ({$urandom, $urandom} % (span | 64'd1)), 1'b0);
          sync_after(span);
          sent += k + 1;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("crank_period_rpm_meter regression: pass");
    end else begin
      $display("crank_period_rpm_meter regression: fail");
    end
    $finish;
  end

endmodule
